// File: design/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the fast system call MSR unit
// Instruction kinds, MSR indexes, descriptor access bytes and the structs
// passed between the top level and the execute logic.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam logic [1:0] KIND_WRMSR = 2'd0;
  localparam logic [1:0] KIND_RDMSR = 2'd1;
  localparam logic [1:0] KIND_ENTER = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  localparam logic [31:0] MSR_CS  = 32'h0000_0174;
  localparam logic [31:0] MSR_ESP = 32'h0000_0175;
  localparam logic [31:0] MSR_EIP = 32'h0000_0176;

  localparam logic [15:0] SEL_MASK   = 16'hFFFC;
  localparam logic [15:0] SS_OFS     = 16'd8;
  localparam logic [15:0] EXIT_CS_OFS = 16'd16;
  localparam logic [15:0] EXIT_SS_OFS = 16'd24;

  localparam logic [7:0] CS_ACCESS = 8'h9B;
  localparam logic [7:0] SS_ACCESS = 8'h93;

  localparam logic [1:0] PL_KERNEL = 2'd0;
  localparam logic [1:0] PL_USER   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ecx_value;
    logic [31:0] edx_value;
    logic [31:0] eax_value;
    logic [1:0]  current_pl;
    logic        real_mode;
  } fsc_req_t;

  typedef struct packed {
    logic [15:0] code_sel;
    logic [31:0] stack_ptr;
    logic [31:0] entry_pt;
  } fsc_msr_t;

  typedef struct packed {
    logic        cs_en;
    logic        esp_en;
    logic        eip_en;
    logic [31:0] data;
  } fsc_wr_t;

  typedef struct packed {
    logic        fault;
    logic        defer_to_parent;
    logic [31:0] read_high;
    logic [31:0] read_low;
    logic        load_segments;
    logic [1:0]  new_pl;
    logic [15:0] cs_selector;
    logic [15:0] ss_selector;
    logic [31:0] new_esp;
    logic [31:0] new_eip;
    logic [7:0]  cs_access_rights;
    logic [7:0]  ss_access_rights;
  } fsc_res_t;

endpackage

// File: design/fsc_exec.sv
// ----------------------------------------------------------------------------
// fsc_exec: execute logic of the fast system call MSR unit
// Checks one request against privilege, mode and index rules, forms the
// result and the MSR write that the request causes.
// ----------------------------------------------------------------------------
module fsc_exec
  import fsc_pkg::*;
(
  input  fsc_req_t req,
  input  fsc_msr_t msr,
  output fsc_res_t res,
  output fsc_wr_t  wr
);

  logic        priv_fault;
  logic        in_range;
  logic        bad_bits;
  logic        call_fault;
  logic [15:0] base;
  logic [15:0] cs_sum;
  logic [15:0] ss_sum;
  logic [1:0]  pl;

  assign priv_fault = (req.current_pl != 2'd0) && !req.real_mode;
  assign in_range   = (req.ecx_value >= MSR_CS) && (req.ecx_value <= MSR_EIP);
  assign bad_bits   = (req.edx_value != 32'd0) ||
                      ((req.ecx_value == MSR_CS) && (req.eax_value[31:16] != 16'd0));
  assign base       = msr.code_sel & SEL_MASK;
  assign call_fault = req.real_mode || (base == 16'd0) ||
                      ((req.kind == KIND_EXIT) && (req.current_pl != 2'd0));

  always_comb begin
    if (req.kind == KIND_EXIT) begin
      pl     = PL_USER;
      cs_sum = base + EXIT_CS_OFS;
      ss_sum = base + EXIT_SS_OFS;
    end else begin
      pl     = PL_KERNEL;
      cs_sum = base;
      ss_sum = base + SS_OFS;
    end
  end

  always_comb begin
    res     = '0;
    wr      = '0;
    wr.data = req.eax_value;
    unique case (req.kind)
      KIND_WRMSR: begin
        if (priv_fault) begin
          res.fault = 1'b1;
        end else if (!in_range) begin
          res.defer_to_parent = 1'b1;
        end else if (bad_bits) begin
          res.fault = 1'b1;
        end else begin
          wr.cs_en  = (req.ecx_value == MSR_CS);
          wr.esp_en = (req.ecx_value == MSR_ESP);
          wr.eip_en = (req.ecx_value == MSR_EIP);
        end
      end
      KIND_RDMSR: begin
        if (priv_fault) begin
          res.fault = 1'b1;
        end else if (!in_range) begin
          res.defer_to_parent = 1'b1;
        end else if (req.ecx_value == MSR_CS) begin
          res.read_low = {16'd0, msr.code_sel};
        end else if (req.ecx_value == MSR_ESP) begin
          res.read_low = msr.stack_ptr;
        end else begin
          res.read_low = msr.entry_pt;
        end
      end
      KIND_ENTER, KIND_EXIT: begin
        if (call_fault) begin
          res.fault = 1'b1;
        end else begin
          res.load_segments    = 1'b1;
          res.new_pl           = pl;
          res.cs_selector      = (cs_sum & SEL_MASK) | {14'd0, pl};
          res.ss_selector      = (ss_sum & SEL_MASK) | {14'd0, pl};
          res.new_esp          = (req.kind == KIND_EXIT) ? req.ecx_value : msr.stack_ptr;
          res.new_eip          = (req.kind == KIND_EXIT) ? req.edx_value : msr.entry_pt;
          res.cs_access_rights = CS_ACCESS | {1'b0, pl, 5'd0};
          res.ss_access_rights = SS_ACCESS | {1'b0, pl, 5'd0};
        end
      end
      default: begin
        res.fault = 1'b1;
      end
    endcase
  end

endmodule

// File: design/fast_system_call_msr_unit.sv
// ----------------------------------------------------------------------------
// fast_system_call_msr_unit: fast system call MSR unit
// Path: an accepted request moves from the input register to the result
// register, where its result waits on out_ready until it is taken.
// Throughput: one request per cycle while out_ready is high; while a result
// waits on out_ready the input register takes one more request, then stalls.
// Reset clears both valid bits and the three call MSRs to zero.
// ----------------------------------------------------------------------------
module fast_system_call_msr_unit
  import fsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] ecx_value,
  input  logic [31:0] edx_value,
  input  logic [31:0] eax_value,
  input  logic [1:0]  current_pl,
  input  logic        real_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fault,
  output logic        defer_to_parent,
  output logic [31:0] read_high,
  output logic [31:0] read_low,
  output logic        load_segments,
  output logic [1:0]  new_pl,
  output logic [15:0] cs_selector,
  output logic [15:0] ss_selector,
  output logic [31:0] new_esp,
  output logic [31:0] new_eip,
  output logic [7:0]  cs_access_rights,
  output logic [7:0]  ss_access_rights
);

  logic     req_valid;
  fsc_req_t req;
  fsc_msr_t msr;
  fsc_res_t res;
  fsc_res_t res_next;
  fsc_wr_t  wr;
  logic     advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  fsc_exec u_exec (
    .req (req),
    .msr (msr),
    .res (res_next),
    .wr  (wr)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req <= '{kind, ecx_value, edx_value, eax_value, current_pl, real_mode};
    end
  end

  // call MSRs, updated as a request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      msr <= '0;
    end else if (advance) begin
      if (wr.cs_en)  msr.code_sel  <= wr.data[15:0];
      if (wr.esp_en) msr.stack_ptr <= wr.data;
      if (wr.eip_en) msr.entry_pt  <= wr.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= req_valid;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign fault            = res.fault;
  assign defer_to_parent  = res.defer_to_parent;
  assign read_high        = res.read_high;
  assign read_low         = res.read_low;
  assign load_segments    = res.load_segments;
  assign new_pl           = res.new_pl;
  assign cs_selector      = res.cs_selector;
  assign ss_selector      = res.ss_selector;
  assign new_esp          = res.new_esp;
  assign new_eip          = res.new_eip;
  assign cs_access_rights = res.cs_access_rights;
  assign ss_access_rights = res.ss_access_rights;

  a_msr_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(msr))
    else $error("call MSR changed without a request moving on");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $countones({wr.cs_en, wr.esp_en, wr.eip_en}) <= 1)
    else $error("more than one call MSR written at once");

  a_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({fault, defer_to_parent, load_segments}) <= 1)
    else $error("result carries conflicting outcomes");

  a_sel_pl: assert property (@(posedge clk) disable iff (rst)
    (out_valid && load_segments) |->
      (cs_selector[1:0] == new_pl) && (ss_selector[1:0] == new_pl))
    else $error("selector privilege bits differ from new privilege");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !advance) |=> req_valid && $stable(req))
    else $error("stalled request lost or changed");

endmodule

// File: test/fast_system_call_msr_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_system_call_msr_unit_tb: self-checking bench for the fast call MSR unit
// Drives MSR reads and writes plus fast enter/exit requests through the
// valid/ready request channel. A scoreboard keeps its own copy of the three
// call MSRs, predicts every result and compares it field by field with what
// the unit returns. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
import fsc_pkg::*;

class msr_scoreboard;
  logic [15:0] code_sel;
  logic [31:0] stack_ptr;
  logic [31:0] entry_pt;
  fsc_res_t    outcomes_due[$];
  int          errors;
  int          n_wr, n_rd, n_enter, n_exit;
  int          n_fault, n_defer, n_load;

  function new();
    code_sel  = '0;
    stack_ptr = '0;
    entry_pt  = '0;
    errors    = 0;
    n_wr = 0; n_rd = 0; n_enter = 0; n_exit = 0;
    n_fault = 0; n_defer = 0; n_load = 0;
  endfunction

  // Execute one instruction against the local MSR copy.
  function fsc_res_t execute_instr(fsc_req_t req);
    fsc_res_t    res;
    logic [15:0] base;
    logic [1:0]  pl;
    res  = '0;
    base = code_sel & SEL_MASK;
    if (req.kind == KIND_WRMSR || req.kind == KIND_RDMSR) begin
      if (req.current_pl != PL_KERNEL && !req.real_mode) begin
        res.fault = 1'b1;
      end else if (req.ecx_value < MSR_CS || req.ecx_value > MSR_EIP) begin
        res.defer_to_parent = 1'b1;
      end else if (req.kind == KIND_WRMSR) begin
        if (req.edx_value != '0 ||
            (req.ecx_value == MSR_CS && req.eax_value[31:16] != '0)) begin
          res.fault = 1'b1;
        end else if (req.ecx_value == MSR_CS) begin
          code_sel = req.eax_value[15:0];
        end else if (req.ecx_value == MSR_ESP) begin
          stack_ptr = req.eax_value;
        end else begin
          entry_pt = req.eax_value;
        end
      end else begin
        if (req.ecx_value == MSR_CS) res.read_low = {16'h0, code_sel};
        else if (req.ecx_value == MSR_ESP) res.read_low = stack_ptr;
        else res.read_low = entry_pt;
      end
    end else if (req.real_mode || base == '0 ||
                 (req.kind == KIND_EXIT && req.current_pl != PL_KERNEL)) begin
      res.fault = 1'b1;
    end else begin
      if (req.kind == KIND_ENTER) begin
        pl              = PL_KERNEL;
        res.cs_selector = (base & SEL_MASK) | {14'h0, pl};
        res.ss_selector = ((base + SS_OFS) & SEL_MASK) | {14'h0, pl};
        res.new_esp     = stack_ptr;
        res.new_eip     = entry_pt;
      end else begin
        pl              = PL_USER;
        res.cs_selector = ((base + EXIT_CS_OFS) & SEL_MASK) | {14'h0, pl};
        res.ss_selector = ((base + EXIT_SS_OFS) & SEL_MASK) | {14'h0, pl};
        res.new_esp     = req.ecx_value;
        res.new_eip     = req.edx_value;
      end
      res.load_segments    = 1'b1;
      res.new_pl           = pl;
      res.cs_access_rights = CS_ACCESS | {1'b0, pl, 5'b0};
      res.ss_access_rights = SS_ACCESS | {1'b0, pl, 5'b0};
    end
    return res;
  endfunction

  function void note_request(fsc_req_t req);
    fsc_res_t res;
    res = execute_instr(req);
    case (req.kind)
      KIND_WRMSR: n_wr++;
      KIND_RDMSR: n_rd++;
      KIND_ENTER: n_enter++;
      default:    n_exit++;
    endcase
    if (res.fault) n_fault++;
    if (res.defer_to_parent) n_defer++;
    if (res.load_segments) n_load++;
    outcomes_due.push_back(res);
  endfunction

  function void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(fsc_res_t got);
    fsc_res_t want;
    if (outcomes_due.size() == 0) begin
      $display("%0t: result with no request outstanding: expected none, actual 0x%0h",
               $time, got);
      errors++;
      return;
    end
    want = outcomes_due.pop_front();
    match_field("fault", 32'(want.fault), 32'(got.fault));
    match_field("defer_to_parent", 32'(want.defer_to_parent), 32'(got.defer_to_parent));
    match_field("read_high", want.read_high, got.read_high);
    match_field("read_low", want.read_low, got.read_low);
    match_field("load_segments", 32'(want.load_segments), 32'(got.load_segments));
    match_field("new_pl", 32'(want.new_pl), 32'(got.new_pl));
    match_field("cs_selector", 32'(want.cs_selector), 32'(got.cs_selector));
    match_field("ss_selector", 32'(want.ss_selector), 32'(got.ss_selector));
    match_field("new_esp", want.new_esp, got.new_esp);
    match_field("new_eip", want.new_eip, got.new_eip);
    match_field("cs_access_rights", 32'(want.cs_access_rights),
                32'(got.cs_access_rights));
    match_field("ss_access_rights", 32'(want.ss_access_rights),
                32'(got.ss_access_rights));
  endfunction

  function int outstanding();
    return outcomes_due.size();
  endfunction
endclass

module fast_system_call_msr_unit_tb;

  localparam int RANDOM_ITEMS = 1525;
  localparam int QUIET_TAIL   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [31:0] ecx_value;
  logic [31:0] edx_value;
  logic [31:0] eax_value;
  logic [1:0]  current_pl;
  logic        real_mode;
  logic        out_valid;
  logic        out_ready;
  logic        fault;
  logic        defer_to_parent;
  logic [31:0] read_high;
  logic [31:0] read_low;
  logic        load_segments;
  logic [1:0]  new_pl;
  logic [15:0] cs_selector;
  logic [15:0] ss_selector;
  logic [31:0] new_esp;
  logic [31:0] new_eip;
  logic [7:0]  cs_access_rights;
  logic [7:0]  ss_access_rights;

  msr_scoreboard sb;
  bit            bursty;
  int            stall_left;
  int            cycle_count;

  fast_system_call_msr_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .ecx_value        (ecx_value),
    .edx_value        (edx_value),
    .eax_value        (eax_value),
    .current_pl       (current_pl),
    .real_mode        (real_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .fault            (fault),
    .defer_to_parent  (defer_to_parent),
    .read_high        (read_high),
    .read_low         (read_low),
    .load_segments    (load_segments),
    .new_pl           (new_pl),
    .cs_selector      (cs_selector),
    .ss_selector      (ss_selector),
    .new_esp          (new_esp),
    .new_eip          (new_eip),
    .cs_access_rights (cs_access_rights),
    .ss_access_rights (ss_access_rights)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Results first: nothing accepted at this edge can already have a result.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result('{fault, defer_to_parent, read_high, read_low, load_segments,
                          new_pl, cs_selector, ss_selector, new_esp, new_eip,
                          cs_access_rights, ss_access_rights});
      end
      if (in_valid && in_ready) begin
        sb.note_request('{kind, ecx_value, edx_value, eax_value, current_pl, real_mode});
      end
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if (bursty && $urandom_range(0, 9) == 0) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  function automatic fsc_req_t make_req(logic [1:0] k, logic [31:0] ecx, logic [31:0] edx,
                                        logic [31:0] eax, logic [1:0] cpl, logic rm);
    fsc_req_t r;
    r.kind       = k;
    r.ecx_value  = ecx;
    r.edx_value  = edx;
    r.eax_value  = eax;
    r.current_pl = cpl;
    r.real_mode  = rm;
    return r;
  endfunction

  // Mostly well-formed: kernel privilege, protected mode, in-range indexes.
  function automatic fsc_req_t random_request();
    fsc_req_t r;
    int       pick;
    r.kind       = 2'($urandom_range(0, 3));
    r.current_pl = ($urandom_range(0, 9) < 7) ? PL_KERNEL : 2'($urandom_range(1, 3));
    r.real_mode  = ($urandom_range(0, 9) == 0);
    r.ecx_value  = $urandom;
    r.edx_value  = $urandom;
    r.eax_value  = $urandom;
    if (r.kind == KIND_WRMSR || r.kind == KIND_RDMSR) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) r.ecx_value = MSR_CS + $urandom_range(0, 2);
      else if (pick < 17) r.ecx_value = 32'h170 + $urandom_range(0, 10);
      if (r.kind == KIND_WRMSR && $urandom_range(0, 9) != 0) r.edx_value = '0;
      if (r.ecx_value == MSR_CS) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) r.eax_value = $urandom_range(0, 3);
        else if (pick == 1) r.eax_value = $urandom;
        else if (pick == 2) r.eax_value = 32'hFFF0 + $urandom_range(0, 15);
        else r.eax_value = $urandom_range(0, 65535);
      end
    end
    return r;
  endfunction

  task automatic send_request(input fsc_req_t r);
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = r.kind;
    ecx_value  = r.ecx_value;
    edx_value  = r.edx_value;
    eax_value  = r.eax_value;
    current_pl = r.current_pl;
    real_mode  = r.real_mode;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    kind        = KIND_WRMSR;
    ecx_value   = '0;
    edx_value   = '0;
    eax_value   = '0;
    current_pl  = PL_KERNEL;
    real_mode   = 1'b0;
    bursty      = 1'b0;
    stall_left  = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reads after reset, zero selector, privilege and foreign index checks.
    send_request(make_req(KIND_RDMSR, MSR_CS,  '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_RDMSR, MSR_ESP, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_RDMSR, MSR_EIP, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_ENTER, '0, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_EXIT,  '0, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_WRMSR, MSR_ESP, '0, 32'h1234, PL_USER, 1'b0));
    send_request(make_req(KIND_RDMSR, MSR_CS,  '0, '0, 2'd1, 1'b0));
    send_request(make_req(KIND_WRMSR, 32'h173, '0, 32'h55, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_RDMSR, 32'h177, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_WRMSR, '1, '1, '1, PL_KERNEL, 1'b0));
    // Bad write bits: nonzero high word, selector above 16 bits.
    send_request(make_req(KIND_WRMSR, MSR_CS,  32'h1, 32'h8, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_WRMSR, MSR_CS,  '0, 32'h0001_0000, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_WRMSR, MSR_EIP, 32'h8000_0000, '0, PL_KERNEL, 1'b0));
    // Real mode lifts the privilege check; all-ones values.
    send_request(make_req(KIND_WRMSR, MSR_CS,  '0, 32'hFFFF, PL_USER, 1'b1));
    send_request(make_req(KIND_WRMSR, MSR_ESP, '0, '1, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_WRMSR, MSR_EIP, '0, '1, 2'd2, 1'b1));
    send_request(make_req(KIND_RDMSR, MSR_CS,  '0, '0, PL_KERNEL, 1'b0));
    // Enter and exit with selector sums wrapping at 16 bits.
    send_request(make_req(KIND_ENTER, '0, '0, '0, PL_KERNEL, 1'b1));
    send_request(make_req(KIND_ENTER, '1, '1, '1, PL_USER, 1'b0));
    send_request(make_req(KIND_EXIT,  '1, '1, '0, PL_USER, 1'b0));
    send_request(make_req(KIND_EXIT,  '1, '1, '1, PL_KERNEL, 1'b0));
    // Selector with only privilege bits set counts as zero.
    send_request(make_req(KIND_WRMSR, MSR_CS,  '0, 32'h3, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_ENTER, '0, '0, '0, PL_KERNEL, 1'b0));
    send_request(make_req(KIND_EXIT,  '0, '0, '0, PL_KERNEL, 1'b0));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      bursty = ((i % 300) >= 60) && (i < RANDOM_ITEMS - QUIET_TAIL);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      send_request(random_request());
    end

    in_valid = 1'b0;
    bursty   = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d MSR writes, %0d MSR reads, %0d fast enters, %0d fast exits",
             sb.n_wr, sb.n_rd, sb.n_enter, sb.n_exit);
    $display("Outcomes: %0d faults, %0d deferred indexes, %0d segment loads; %0d errors",
             sb.n_fault, sb.n_defer, sb.n_load, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
